FILE: rtl/core/wsfe_pkg.sv
// Shared types and constants for the WebSocket frame encoder.
`timescale 1ns / 1ps

package wsfe_pkg;

  localparam int unsigned LenW  = 63;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 4;

  localparam logic [ByteW-1:0] OpText      = 8'h81;
  localparam logic [ByteW-1:0] OpBinary    = 8'h82;
  localparam logic [ByteW-1:0] Len16Code   = 8'd126;
  localparam logic [ByteW-1:0] Len64Code   = 8'd127;
  localparam logic [LenW-1:0]  LenShortMax = 63'd125;
  localparam logic [LenW-1:0]  Len16Max    = 63'd65535;

  // What the work stage is emitting.
  typedef enum logic [1:0] {
    KindShort   = 2'd0,
    Kind16      = 2'd1,
    Kind64      = 2'd2,
    KindPayload = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              is_binary;
    logic [LenW-1:0]   len;
    logic [ByteW-1:0]  data;
    logic              frame_end;  // empty frame on header, final byte on payload
    logic              overrun;
  } wk_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_header;
    logic             frame_end;
    logic             run_last;
    logic             overrun;
  } res_t;

  // Index of the final beat for each kind.
  function automatic logic [IdxW-1:0] last_idx(kind_e kind);
    logic [IdxW-1:0] r;
    unique case (kind)
      KindShort:   r = 4'd1;
      Kind16:      r = 4'd3;
      Kind64:      r = 4'd9;
      KindPayload: r = 4'd0;
      default:     r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/wsfe_ifs.sv
// Valid/ready channel interfaces for input items and encoded bytes.
`timescale 1ns / 1ps

interface wsfe_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        is_binary;
  logic [62:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, mode, is_binary, payload_length, data_byte, input ready);
  modport sink   (input valid, mode, is_binary, payload_length, data_byte, output ready);
endinterface

interface wsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       frame_end;
  logic       run_last;
  logic       overrun;

  modport source (output valid, out_byte, is_header, frame_end, run_last, overrun, input ready);
  modport sink   (input valid, out_byte, is_header, frame_end, run_last, overrun, output ready);
endinterface

FILE: rtl/core/wsfe_byte_sel.sv
// Picks the encoded byte and its flags for one beat of the work stage.
`timescale 1ns / 1ps

module wsfe_byte_sel
  import wsfe_pkg::*;
(
  input  wk_t             wk_i,
  input  logic [IdxW-1:0] idx_i,
  output res_t            res_o
);

  logic [63:0]      len64;
  logic [2:0]       bsel;
  logic [ByteW-1:0] hbyte;
  logic             last;

  assign len64 = {1'b0, wk_i.len};
  // big-endian byte of the 64-bit length: beat 2 is the top byte
  assign bsel  = 3'(4'd9 - idx_i);
  assign last  = (idx_i == last_idx(wk_i.kind));

  always_comb begin
    hbyte = '0;
    if (idx_i == 4'd0) begin
      hbyte = wk_i.is_binary ? OpBinary : OpText;
    end else if (idx_i == 4'd1) begin
      unique case (wk_i.kind)
        KindShort: hbyte = {1'b0, wk_i.len[6:0]};
        Kind16:    hbyte = Len16Code;
        Kind64:    hbyte = Len64Code;
        default:   hbyte = '0;
      endcase
    end else if (wk_i.kind == Kind16) begin
      hbyte = (idx_i == 4'd2) ? wk_i.len[15:8] : wk_i.len[7:0];
    end else begin
      hbyte = len64[{bsel, 3'b000} +: 8];
    end
  end

  always_comb begin
    if (wk_i.kind == KindPayload) begin
      res_o.out_byte  = wk_i.overrun ? '0 : wk_i.data;
      res_o.is_header = 1'b0;
      res_o.frame_end = wk_i.frame_end;
      res_o.run_last  = 1'b1;
      res_o.overrun   = wk_i.overrun;
    end else begin
      res_o.out_byte  = hbyte;
      res_o.is_header = 1'b1;
      res_o.frame_end = last & wk_i.frame_end;
      res_o.run_last  = last;
      res_o.overrun   = 1'b0;
    end
  end

endmodule

FILE: rtl/core/websocket_frame_encoder.sv
// WebSocket frame encoder top level: unmasked RFC 6455 header plus payload pass-through.
// An accepted beat is registered in the work stage; its bytes then pass through the output register.
// Throughput: one output byte per cycle while the receiver is ready; a header beat yields
//   2, 4 or 10 bytes (inline, 16-bit or 64-bit length), a payload beat 1.
// Reset (async, active low) clears the byte counter and both valid flags.
`timescale 1ns / 1ps

module websocket_frame_encoder
  import wsfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfe_in_if.sink     in_i,
  wsfe_out_if.source  out_o
);

  // Work stage: holds one item while its beats are produced.
  logic            wk_valid_q;
  wk_t             wk_q, wk_d;
  logic [IdxW-1:0] idx_q;

  // Output register.
  logic            out_valid_q;
  res_t            out_q;

  // Payload bytes still owed to the current frame.
  logic [LenW-1:0] bytes_left_q, bytes_left_d;

  res_t sel_res;
  logic out_free;
  logic emit;
  logic wk_last;
  logic in_fire;

  wsfe_byte_sel u_sel (
    .wk_i  (wk_q),
    .idx_i (idx_q),
    .res_o (sel_res)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign emit       = wk_valid_q && out_free;
  assign wk_last    = (idx_q == last_idx(wk_q.kind));
  // take a new item once the work stage is empty or handing off its last beat
  assign in_i.ready = !wk_valid_q || (emit && wk_last);
  assign in_fire    = in_i.valid && in_i.ready;

  // Decode the incoming item; the counter moves in accept order.
  always_comb begin
    wk_d           = wk_q;
    bytes_left_d   = bytes_left_q;
    wk_d.is_binary = in_i.is_binary;
    wk_d.len       = in_i.payload_length;
    wk_d.data      = in_i.data_byte;
    wk_d.overrun   = 1'b0;
    if (!in_i.mode) begin
      if (in_i.payload_length > Len16Max) begin
        wk_d.kind = Kind64;
      end else if (in_i.payload_length > LenShortMax) begin
        wk_d.kind = Kind16;
      end else begin
        wk_d.kind = KindShort;
      end
      wk_d.frame_end = (in_i.payload_length == '0);
      bytes_left_d   = in_i.payload_length;
    end else begin
      wk_d.kind      = KindPayload;
      wk_d.overrun   = (bytes_left_q == '0);
      wk_d.frame_end = (bytes_left_q == LenW'(1));
      if (bytes_left_q != '0) begin
        bytes_left_d = bytes_left_q - LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk_valid_q   <= 1'b0;
      idx_q        <= '0;
      bytes_left_q <= '0;
    end else begin
      if (in_fire) begin
        wk_valid_q   <= 1'b1;
        idx_q        <= '0;
        bytes_left_q <= bytes_left_d;
      end else if (emit) begin
        if (wk_last) begin
          wk_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      wk_q <= wk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= wk_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= sel_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_q.out_byte;
  assign out_o.is_header = out_q.is_header;
  assign out_o.frame_end = out_q.frame_end;
  assign out_o.run_last  = out_q.run_last;
  assign out_o.overrun   = out_q.overrun;

endmodule

FILE: tb/sv/websocket_frame_encoder_checker.sv
// Checker for the WebSocket frame encoder: predicts encoded bytes and compares them.
`timescale 1ns / 1ps

module websocket_frame_encoder_checker
  import wsfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfe_in_if          in_mon,
  wsfe_out_if         out_mon,
  output int unsigned fail_o,
  output int unsigned owed_o
);

  logic [LenW-1:0] frame_left;   // payload bytes still owed by the open frame
  res_t            owed_q[$];    // encoded bytes predicted but not yet seen
  int unsigned     fail_cnt = 0;

  function automatic res_t make_byte(logic [ByteW-1:0] b, logic hdr, logic eof,
                                     logic last, logic ovr);
    res_t r;
    r.out_byte  = b;
    r.is_header = hdr;
    r.frame_end = eof;
    r.run_last  = last;
    r.overrun   = ovr;
    return r;
  endfunction

  // Encode one accepted beat into the bytes it must produce.
  function automatic void encode_beat(logic mode, logic bin, logic [LenW-1:0] len,
                                      logic [ByteW-1:0] data);
    logic [ByteW-1:0] hb[10];
    logic [63:0]      wide;
    int               n;
    wide = {1'b0, len};
    if (mode == 1'b0) begin
      hb[0] = bin ? OpBinary : OpText;
      if (len > Len16Max) begin
        hb[1] = Len64Code;
        for (int k = 0; k < 8; k++) hb[2+k] = wide[63-8*k -: 8];
        n = 10;
      end else if (len > LenShortMax) begin
        hb[1] = Len16Code;
        hb[2] = len[15:8];
        hb[3] = len[7:0];
        n = 4;
      end else begin
        hb[1] = len[7:0];
        n = 2;
      end
      frame_left = len;
      for (int k = 0; k < n; k++)
        owed_q.push_back(make_byte(hb[k], 1'b1, (k == n-1) && (len == '0), k == n-1, 1'b0));
    end else if (frame_left == '0) begin
      owed_q.push_back(make_byte('0, 1'b0, 1'b0, 1'b1, 1'b1));
    end else begin
      frame_left = frame_left - 1'b1;
      owed_q.push_back(make_byte(data, 1'b0, frame_left == '0, 1'b1, 1'b0));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      frame_left = '0;
      owed_q.delete();
    end else begin
      // output side first: a byte can never stem from a beat taken at this edge
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected output beat: out_byte %0h", out_mon.out_byte);
          fail_cnt++;
        end else begin
          want = owed_q.pop_front();
          if (out_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_mon.out_byte);
            fail_cnt++;
          end
          if (out_mon.is_header !== want.is_header) begin
            $error("is_header: expected %0b, got %0b", want.is_header, out_mon.is_header);
            fail_cnt++;
          end
          if (out_mon.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_mon.frame_end);
            fail_cnt++;
          end
          if (out_mon.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_mon.run_last);
            fail_cnt++;
          end
          if (out_mon.overrun !== want.overrun) begin
            $error("overrun: expected %0b, got %0b", want.overrun, out_mon.overrun);
            fail_cnt++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        encode_beat(in_mon.mode, in_mon.is_binary, in_mon.payload_length, in_mon.data_byte);
    end
    fail_o <= fail_cnt;
    owed_o <= owed_q.size();
  end

endmodule

FILE: tb/sv/websocket_frame_encoder_tb.sv
// Testbench top for the WebSocket frame encoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module websocket_frame_encoder_tb
  import wsfe_pkg::*;
();

  // Generous: worst case is ~230 beats x 10 bytes x long stalls, far below this.
  localparam int unsigned CycleLimit = 200000;
  // Output passes through the work stage and the output register; give it plenty of slack.
  localparam int unsigned DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fails;
  int unsigned owed;
  int unsigned gap_pct   = 0;  // sender idle chance per beat, percent
  int unsigned stall_pct = 0;  // receiver stall chance per cycle, percent
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt  = 0;

  wsfe_in_if  in_ch ();
  wsfe_out_if out_ch ();

  websocket_frame_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  websocket_frame_encoder_checker chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .fail_o  (fails),
    .owed_o  (owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random backpressure at the rate the current phase asks for.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a missing byte ends the run here.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("websocket_frame_encoder test failed");
    $finish;
  end

  function automatic logic [LenW-1:0] rand_len();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[LenW-1:0];
  endfunction

  // One beat on the input channel; returns once it has been taken.
  task automatic send_beat(logic mode, logic bin, logic [LenW-1:0] len, logic [ByteW-1:0] data);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.is_binary      <= bin;
    in_ch.payload_length <= len;
    in_ch.data_byte      <= data;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Unused fields carry junk so every input bit toggles.
  task automatic send_header(logic bin, logic [LenW-1:0] len);
    send_beat(1'b0, bin, len, ByteW'($urandom));
  endtask

  task automatic send_payload(logic [ByteW-1:0] data);
    send_beat(1'b1, 1'($urandom), rand_len(), data);
  endtask

  // Sender holds off until every predicted byte has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  // Random traffic: mostly well-formed frames with small payloads, long lengths
  // cut short by the next header, plus stray bytes that hit the overrun path.
  task automatic run_traffic(int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned nbytes;
    int unsigned extra;
    logic [LenW-1:0] len;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      pick  = $urandom_range(99);
      extra = 0;
      if (pick < 55) begin
        len    = LenW'($urandom_range(0, 10));
        nbytes = 32'(len);
      end else if (pick < 65) begin
        len    = LenW'($urandom_range(11, 125));
        nbytes = $urandom_range(0, 4);
      end else if (pick < 77) begin
        // 16-bit length; lean on the edges now and then
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0:       len = LenShortMax + 1'b1;
            1:       len = LenShortMax + 2'd2;
            2:       len = Len16Max - 1'b1;
            default: len = Len16Max;
          endcase
        end else begin
          len = LenW'($urandom_range(126, 65535));
        end
        nbytes = $urandom_range(0, 4);
      end else if (pick < 87) begin
        len    = rand_len() >> $urandom_range(0, 46);
        nbytes = $urandom_range(0, 3);
      end else if (pick < 93) begin
        // complete frame followed by bytes nobody asked for
        len    = LenW'($urandom_range(0, 3));
        nbytes = 32'(len);
        extra  = $urandom_range(1, 3);
      end else begin
        // stray payload with no header in front
        repeat ($urandom_range(1, 3)) send_payload(ByteW'($urandom));
        continue;
      end
      send_header(1'($urandom), len);
      repeat (nbytes + extra) send_payload(ByteW'($urandom));
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.mode           <= 1'b0;
    in_ch.is_binary      <= 1'b0;
    in_ch.payload_length <= '0;
    in_ch.data_byte      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_payload(8'h3C);                 // byte with no frame open: overrun
    send_header(1'b0, '0);               // empty text frame
    send_header(1'b1, '0);               // empty binary frame
    send_header(1'b0, LenW'(1));
    send_payload(8'h00);                 // closes the one-byte frame
    send_header(1'b1, LenShortMax);      // largest inline length
    send_payload(8'hFF);
    send_header(1'b0, LenShortMax + 1'b1);  // smallest 16-bit length, abandons the last
    send_payload(8'hA5);
    send_header(1'b1, Len16Max);         // largest 16-bit length
    send_payload(8'h5A);
    send_header(1'b0, Len16Max + 1'b1);  // smallest 64-bit length
    send_header(1'b1, {LenW{1'b1}});     // largest length the field holds
    send_payload(8'hFF);
    send_header(1'b0, LenW'(3));
    send_payload(8'h01);
    send_payload(8'h80);
    send_payload(8'h7F);                 // frame end
    send_payload(8'hC3);                 // one past the end: overrun
    wait_drained();

    // Phase 1: no idling, with one 16-bit frame carried through to its end.
    gap_pct   = 0;
    stall_pct = 0;
    send_header(1'($urandom), LenShortMax + 1'b1);
    repeat (126) send_payload(ByteW'($urandom));
    run_traffic(16);
    wait_drained();

    // Phase 2: sender mostly idle.
    gap_pct   = 65;
    stall_pct = 0;
    run_traffic(16);
    wait_drained();

    // Phase 3: receiver mostly stalled.
    gap_pct   = 0;
    stall_pct = 65;
    run_traffic(16);
    wait_drained();

    // Phase 4: both sides idle now and then.
    gap_pct   = 21;
    stall_pct = 21;
    run_traffic(16);
    wait_drained();

    stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0 && owed == 0) begin
      $display("websocket_frame_encoder test passed");
    end else begin
      $display("websocket_frame_encoder test failed");
    end
    $finish;
  end

endmodule
